>>> hw/rtl/wsenc_pkg.sv
// Shared types, constants and the bit pattern function of the WS2812 SPI encoder.
package wsenc_pkg;

  localparam int LATCH_WORDS_DEF = 16;
  localparam logic [2:0] CPP_RESET = 3'd3;
  localparam logic [2:0] CPP_RGBW = 3'd4;
  localparam logic [3:0] NIB_ONE = 4'b1100;
  localparam logic [3:0] NIB_ZERO = 4'b1000;
  localparam logic [1:0] PHASE_START = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD = 2'd2;

  typedef struct packed {
    logic [7:0] channel_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] spi_word;
    logic        is_latch;
    logic        last;
  } out_item_t;

  // Words to emit for one request: up to two data bytes, then optional latch words.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [1:0] ndata;
    logic       latch;
  } job_t;

  function automatic logic [31:0] encode_byte(input logic [7:0] b);
    logic [31:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      w[4*i +: 4] = b[i] ? NIB_ONE : NIB_ZERO;
    end
    return w;
  endfunction

endpackage

>>> hw/rtl/wsenc_front.sv
// Pixel tracking: holds the first byte of a pixel and decides the words for each request.
module wsenc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_wr_data,
  input  logic               accept,
  input  wsenc_pkg::in_item_t item,
  output logic               job_load,
  output wsenc_pkg::job_t    job
);
  import wsenc_pkg::*;

  logic [2:0] channels_per_pixel;
  logic [1:0] pixel_phase, pixel_phase_next;
  logic [7:0] held_byte, held_byte_next;
  logic       holding, holding_next;
  logic       cpp4;
  logic [2:0] phase_inc;
  logic [2:0] cpp;

  assign cpp4 = (channels_per_pixel == CPP_RGBW);
  assign cpp = cpp4 ? 3'd4 : 3'd3;
  assign phase_inc = {1'b0, pixel_phase} + 3'd1;

  always_comb begin
    pixel_phase_next = pixel_phase;
    held_byte_next = held_byte;
    holding_next = holding;
    job = '0;
    job.byte0 = item.channel_byte;
    job.byte1 = held_byte;
    if (holding) begin
      // Second byte of the pixel: send it first, then the held one.
      // A pixel has at least three bytes, so the third one follows unless the frame ends here.
      job.ndata = 2'd2;
      holding_next = 1'b0;
      pixel_phase_next = PHASE_THIRD;
    end else if (pixel_phase == PHASE_START) begin
      if (item.frame_end) begin
        job.ndata = 2'd1;
      end else begin
        held_byte_next = item.channel_byte;
        holding_next = 1'b1;
        pixel_phase_next = PHASE_SECOND;
      end
    end else begin
      job.ndata = 2'd1;
      pixel_phase_next = (phase_inc >= cpp) ? PHASE_START : phase_inc[1:0];
    end
    if (item.frame_end) begin
      job.latch = 1'b1;
      pixel_phase_next = PHASE_START;
      holding_next = 1'b0;
    end
  end

  assign job_load = accept && ((job.ndata != 2'd0) || job.latch);

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_per_pixel <= CPP_RESET;
      pixel_phase <= PHASE_START;
      held_byte <= '0;
      holding <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        channels_per_pixel <= cfg_wr_data;
      end
      if (accept) begin
        pixel_phase <= pixel_phase_next;
        held_byte <= held_byte_next;
        holding <= holding_next;
      end
    end
  end

endmodule

>>> hw/rtl/wsenc_emit.sv
// Word sequencer and output register: emits one SPI word per cycle for the current job while out_stall is low.
module wsenc_emit #(
  parameter int LATCH_WORDS = wsenc_pkg::LATCH_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_load,
  input  wsenc_pkg::job_t     job,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output wsenc_pkg::out_item_t out_item
);
  import wsenc_pkg::*;

  localparam int CW = $clog2(LATCH_WORDS + 3);
  localparam logic [CW-1:0] LATCH_CNT = CW'(LATCH_WORDS);

  job_t          cur;
  logic          job_busy;
  logic [CW-1:0] pos;
  logic [CW-1:0] total_m1;
  logic [CW-1:0] total_next;
  logic          out_free;
  logic          take;
  logic          job_end;
  out_item_t     word;

  assign out_free = !out_valid || !out_stall;
  assign take = job_busy && out_free;
  assign job_end = (pos == total_m1);
  assign in_stall = job_busy && !(out_free && job_end);
  assign total_next = CW'(job.ndata) + (job.latch ? LATCH_CNT : '0) - CW'(1);

  always_comb begin
    word = '0;
    word.last = job_end;
    if (pos < CW'(cur.ndata)) begin
      word.spi_word = encode_byte((pos == '0) ? cur.byte0 : cur.byte1);
    end else begin
      word.is_latch = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_busy <= 1'b0;
      pos <= '0;
      out_valid <= 1'b0;
    end else begin
      if (job_load) begin
        job_busy <= 1'b1;
        pos <= '0;
      end else if (take) begin
        if (job_end) begin
          job_busy <= 1'b0;
        end
        pos <= pos + CW'(1);
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      cur <= job;
      total_m1 <= total_next;
    end
    if (take) begin
      out_item <= word;
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    job_busy |-> pos <= total_m1)
    else $error("word position ran past the end of its job");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    job_load |-> (!job_busy || (out_free && job_end)))
    else $error("job loaded while the previous job was still emitting");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    take && job_end |=> out_valid && out_item.last)
    else $error("final word of a job was not marked last");

  a_latch_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.is_latch |-> out_item.spi_word == 32'd0)
    else $error("latch word carries nonzero data");

endmodule

>>> hw/rtl/ws2812_spi_frame_encoder_unit.sv
// Top level of the WS2812 SPI frame encoder: pixel tracking plus word sequencer.
// An accepted request is loaded as a job; its first word is then registered at the output.
// The sequencer emits one SPI word per cycle while out_stall is low; a request causes one
// or two data words, plus LATCH_WORDS latch words at frame end.
// A held first byte causes no word and the next request is taken in the following cycle.
// Reset is synchronous: clears pixel state and the sequencer, channels_per_pixel returns to 3.
module ws2812_spi_frame_encoder_unit #(
  parameter int LATCH_WORDS = wsenc_pkg::LATCH_WORDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [2:0]           cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wsenc_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wsenc_pkg::out_item_t out_item
);
  import wsenc_pkg::*;

  logic accept;
  logic job_load;
  job_t job;

  assign accept = in_valid && !in_stall;

  wsenc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .item        (in_item),
    .job_load    (job_load),
    .job         (job)
  );

  wsenc_emit #(
    .LATCH_WORDS (LATCH_WORDS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_load  (job_load),
    .job       (job),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
